/* sv/sha1s_pkg.sv */
// Shared types and constants for the SHA-1 stream hasher.
`default_nettype none

package sha1s_pkg;

  // Round constants, one per group of 20 rounds
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  // Initial chaining value
  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam int         NUM_WORDS  = 5;
  localparam int         NUM_ROUNDS = 80;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] FILL_LAST  = 6'd63;

  // Source of the byte written into the block buffer
  typedef enum logic [1:0] {
    SEL_DATA  = 2'd0,
    SEL_PAD80 = 2'd1,
    SEL_ZERO  = 2'd2,
    SEL_LEN   = 2'd3
  } byte_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      wr_byte;    // write one byte at the fill position
    byte_sel_t sel;        // which byte to write
    logic      add_len;    // count eight more message bits
    logic      load_work;  // load working vars from chain, restart rounds
    logic      round_step; // run one compression round
    logic      fold;       // add working vars into chain
    logic      emit_next;  // advance the digest word pointer
    logic      init;       // return chain, length and pointer to start
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
    logic       emit_last;
  } dp_stat_t;

endpackage

`default_nettype wire

/* sv/sha1s_if.sv */
// Valid/ready channel interfaces for the input and digest items.
`default_nettype none

interface sha1s_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface sha1s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

/* sv/sha1s_datapath.sv */
// Datapath: block buffer with schedule window, round unit, chain and length.
`default_nettype none

module sha1s_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sha1s_pkg::dp_cmd_t cmd,
  input  wire logic [7:0]         data_byte,
  output sha1s_pkg::dp_stat_t     stat,
  output logic [31:0]             digest_word,
  output logic [2:0]              word_index
);
  import sha1s_pkg::*;

  logic [31:0] chain [NUM_WORDS];
  logic [31:0] wk    [NUM_WORDS];   // a, b, c, d, e
  logic [31:0] w     [16];          // block words, then schedule window
  logic [63:0] len;
  logic [5:0]  fill;
  logic [6:0]  rnd;
  logic [2:0]  emit_idx;

  logic [7:0]  wr_data;
  logic [31:0] cur_w;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;

  // Byte source selection
  always_comb begin
    unique case (cmd.sel)
      SEL_DATA:  wr_data = data_byte;
      SEL_PAD80: wr_data = PAD_BYTE;
      SEL_ZERO:  wr_data = '0;
      SEL_LEN:   wr_data = len[{~fill[2:0], 3'b000} +: 8];
    endcase
  end

  // Round function, constant and schedule word
  always_comb begin
    cur_w = (rnd < 7'd16) ? w[0]
          : {w[13][30:0] ^ w[8][30:0] ^ w[2][30:0] ^ w[0][30:0],
             w[13][31] ^ w[8][31] ^ w[2][31] ^ w[0][31]};
    if (rnd < 7'd20) begin
      f_val = (wk[1] & wk[2]) | (~wk[1] & wk[3]);
      k_val = K_0;
    end else if (rnd < 7'd40) begin
      f_val = wk[1] ^ wk[2] ^ wk[3];
      k_val = K_1;
    end else if (rnd < 7'd60) begin
      f_val = (wk[1] & wk[2]) | (wk[1] & wk[3]) | (wk[2] & wk[3]);
      k_val = K_2;
    end else begin
      f_val = wk[1] ^ wk[2] ^ wk[3];
      k_val = K_3;
    end
    t_val = {wk[0][26:0], wk[0][31:27]} + f_val + wk[4] + cur_w + k_val;
  end

  // Block buffer: byte writes while filling, word shift while compressing
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      w[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_data;
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= cur_w;
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        wk[i] <= chain[i];
      end
    end else if (cmd.round_step) begin
      wk[0] <= t_val;
      wk[1] <= wk[0];
      wk[2] <= {wk[1][1:0], wk[1][31:2]};
      wk[3] <= wk[2];
      wk[4] <= wk[3];
    end
  end

  // Control counters, length and chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain[i] <= SHA1_IV[i];
      end
      len      <= '0;
      fill     <= '0;
      rnd      <= '0;
      emit_idx <= '0;
    end else begin
      if (cmd.wr_byte) fill <= fill + 6'd1;
      if (cmd.add_len) len  <= len + 64'd8;
      if (cmd.load_work) begin
        rnd <= '0;
      end else if (cmd.round_step) begin
        rnd <= rnd + 7'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          chain[i] <= chain[i] + wk[i];
        end
      end
      if (cmd.emit_next) emit_idx <= emit_idx + 3'd1;
      if (cmd.init) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          chain[i] <= SHA1_IV[i];
        end
        len      <= '0;
        emit_idx <= '0;
      end
    end
  end

  // Digest word selection
  always_comb begin
    case (emit_idx)
      3'd0:    digest_word = chain[0];
      3'd1:    digest_word = chain[1];
      3'd2:    digest_word = chain[2];
      3'd3:    digest_word = chain[3];
      default: digest_word = chain[4];
    endcase
  end

  assign word_index      = emit_idx;
  assign stat.fill       = fill;
  assign stat.round_last = (rnd == 7'(NUM_ROUNDS - 1));
  assign stat.emit_last  = (emit_idx == 3'(NUM_WORDS - 1));

endmodule

`default_nettype wire

/* sv/sha1s_ctrl.sv */
// Controller: absorb, padding, compression sequencing and digest output.
`default_nettype none

module sha1s_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                operation,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire sha1s_pkg::dp_stat_t stat,
  output sha1s_pkg::dp_cmd_t       cmd
);
  import sha1s_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   finishing, finishing_next;
  logic   len_phase, len_phase_next;
  logic   accept;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign accept    = in_valid && in_ready;

  // Next state and datapath commands
  always_comb begin
    state_next     = state;
    finishing_next = finishing;
    len_phase_next = len_phase;
    cmd            = '0;
    cmd.sel        = SEL_DATA;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.wr_byte   = 1'b1;
          cmd.sel       = operation ? SEL_PAD80 : SEL_DATA;
          cmd.add_len   = !operation;
          cmd.load_work = (stat.fill == FILL_LAST);
          finishing_next = operation;
          if (stat.fill == FILL_LAST) begin
            state_next = ST_ROUND;
          end else if (operation) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.wr_byte   = 1'b1;
        cmd.sel       = (len_phase || stat.fill == LEN_START) ? SEL_LEN : SEL_ZERO;
        cmd.load_work = (stat.fill == FILL_LAST);
        if (stat.fill == LEN_START) len_phase_next = 1'b1;
        if (stat.fill == FILL_LAST) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (stat.round_last) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (len_phase) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          cmd.emit_next = 1'b1;
          if (stat.emit_last) begin
            cmd.init       = 1'b1;
            finishing_next = 1'b0;
            len_phase_next = 1'b0;
            state_next     = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      finishing <= 1'b0;
      len_phase <= 1'b0;
    end else begin
      state     <= state_next;
      finishing <= finishing_next;
      len_phase <= len_phase_next;
    end
  end

endmodule

`default_nettype wire

/* sv/sha1_stream_hasher.sv */
// Top level of the streaming SHA-1 hasher.
//
// Each absorb item carries one message byte; the 64th byte of a block starts
// an 80-round compression on a single shared round unit (one round per cycle)
// followed by a chaining-value update. A finish item writes the 0x80 byte,
// then zero padding and the 64-bit big-endian bit length one byte per cycle,
// runs one or two compressions, and then offers the five digest words as five
// items, word 0 first, with last_word set on word 4. The input is not ready
// while a block is compressed, padded or the digest is being delivered; after
// the last digest word the block is back at its initial state for a new
// message.
`default_nettype none

module sha1_stream_hasher (
  input  wire logic    clk,
  input  wire logic    rst,
  sha1s_in_if.sink     din,
  sha1s_out_if.source  dout
);
  import sha1s_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha1s_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .operation (din.operation),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sha1s_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (din.data_byte),
    .stat        (stat),
    .digest_word (dout.digest_word),
    .word_index  (dout.word_index)
  );

  assign dout.last_word = stat.emit_last;

endmodule

`default_nettype wire

/* sv/sha1s_checker.sv */
// Port-level checks for the SHA-1 stream hasher, bound to the top level.
`default_nettype none

module sha1s_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        operation,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  word_index,
  input wire logic        last_word
);

  // Digest output and input acceptance never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("input ready while digest items pending");

  // Last flag marks word four and nothing else
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd4)))
    else $error("last_word does not match word_index");

  // Digest words follow one another in order
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_word) |=>
      (out_valid && word_index == 3'($past(word_index) + 3'd1)))
    else $error("digest word sequence broken");

  // An absorbed byte never produces a result in the next cycle
  a_absorb_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !operation) |=> !out_valid)
    else $error("result after absorb item");

  // A finish item keeps the input busy while padding
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && operation) |=> !in_ready)
    else $error("input ready right after finish item");

endmodule

bind sha1_stream_hasher sha1s_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (din.valid),
  .in_ready   (din.ready),
  .operation  (din.operation),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .word_index (dout.word_index),
  .last_word  (dout.last_word)
);

`default_nettype wire

/* tb/sha1_digest_checker.sv */
// Digest checker for the SHA-1 stream hasher: watches both channels, predicts, compares.

module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        din_valid,
  input  logic        din_ready,
  input  logic        din_operation,
  input  logic [7:0]  din_data_byte,
  input  logic        dout_valid,
  input  logic        dout_ready,
  input  logic [31:0] dout_digest_word,
  input  logic [2:0]  dout_word_index,
  input  logic        dout_last_word,
  output int          mismatches,
  output int          words_seen,
  output int          words_pending
);
  import sha1s_pkg::*;

  localparam logic OP_ABSORB = 1'b0;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  // Predicted hasher state
  logic [31:0]  chain_h [NUM_WORDS];
  logic [7:0]   blk [64];
  logic [5:0]   fill;
  logic [63:0]  bit_len;
  digest_item_t digest_q [$];
  digest_item_t want;

  task automatic note_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [31:0] rol(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < NUM_WORDS; i++) chain_h[i] = SHA1_IV[i];
    fill = '0;
    bit_len = '0;
  endfunction

  // 80-round compression of the buffered block into the chain
  function automatic void compress_block();
    logic [31:0] w [NUM_ROUNDS];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++)
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    for (int r = 16; r < NUM_ROUNDS; r++)
      w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_2;
      end else begin
        f = b ^ c ^ d;
        k = K_3;
      end
      t = rol(a, 5) + f + e + w[r] + k;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // fill is 6 bits wide, so it wraps to zero on a full block
  function automatic void buffer_byte(logic [7:0] v);
    blk[fill] = v;
    fill = fill + 6'd1;
    if (fill == 6'd0) compress_block();
  endfunction

  // Pad, append the bit length, queue the five digest words, start over
  function automatic void close_message();
    logic [63:0] len;
    len = bit_len;
    buffer_byte(PAD_BYTE);
    while (fill != LEN_START) buffer_byte(8'h00);
    for (int i = 7; i >= 0; i--) buffer_byte(len[8*i +: 8]);
    for (int i = 0; i < NUM_WORDS; i++)
      digest_q.push_back('{word: chain_h[i], index: 3'(i), last: (i == NUM_WORDS - 1)});
    restart_message();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restart_message();
      digest_q.delete();
      mismatches = 0;
      words_seen <= 0;
      words_pending <= 0;
    end else begin
      // Compare each digest word with the oldest prediction
      if (dout_valid && dout_ready) begin
        if (digest_q.size() == 0) begin
          note_mismatch($sformatf("unexpected digest word %h index %0d last %0b",
                                  dout_digest_word, dout_word_index, dout_last_word));
        end else begin
          want = digest_q.pop_front();
          if (dout_digest_word !== want.word)
            note_mismatch($sformatf("digest_word %h, predicted %h (index %0d)",
                                    dout_digest_word, want.word, want.index));
          if (dout_word_index !== want.index)
            note_mismatch($sformatf("word_index %0d, predicted %0d",
                                    dout_word_index, want.index));
          if (dout_last_word !== want.last)
            note_mismatch($sformatf("last_word %0b, predicted %0b (index %0d)",
                                    dout_last_word, want.last, want.index));
        end
        words_seen <= words_seen + 1;
      end
      // Advance the prediction on each accepted input item
      if (din_valid && din_ready) begin
        if (din_operation == OP_ABSORB) begin
          buffer_byte(din_data_byte);
          bit_len = bit_len + 64'd8;
        end else begin
          close_message();
        end
      end
      words_pending <= digest_q.size();
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top for the SHA-1 stream hasher: clock, reset, stimulus and verdict.

module tb;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;
  localparam int   HOLD_CYCLES = 600;
  localparam int   DRAIN_CYCLES = 300;
  localparam int   HOLD_MSG_LEN = 5;
  localparam int   NUM_DIGEST_WORDS = sha1s_pkg::NUM_WORDS;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha1s_in_if  din ();
  sha1s_out_if dout ();

  int mismatches;
  int words_seen;
  int words_pending;
  int items;
  int finishes;
  bit tx_gaps;
  bit rx_gaps;
  bit hold_req;

  sha1_stream_hasher i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  sha1_digest_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .din_valid        (din.valid),
    .din_ready        (din.ready),
    .din_operation    (din.operation),
    .din_data_byte    (din.data_byte),
    .dout_valid       (dout.valid),
    .dout_ready       (dout.ready),
    .dout_digest_word (dout.digest_word),
    .dout_word_index  (dout.word_index),
    .dout_last_word   (dout.last_word),
    .mismatches       (mismatches),
    .words_seen       (words_seen),
    .words_pending    (words_pending)
  );

  always #2 clk = ~clk;

  // Run limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one item, with an occasional idle burst first
  task automatic send_item(logic op, logic [7:0] b);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      din.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    din.valid <= 1'b1;
    din.operation <= op;
    din.data_byte <= b;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    items++;
    if (op == OP_FINISH) finishes++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    send_item(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Lengths cluster around the one- and two-block padding boundaries
  function automatic int pick_length();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom_range(0, 8);
    if (sel < 7) return $urandom_range(52, 68);
    if (sel < 9) return $urandom_range(0, 40);
    return $urandom_range(110, 130);
  endfunction

  task automatic wait_digests();
    din.valid <= 1'b0;
    while (words_seen < NUM_DIGEST_WORDS * finishes) @(posedge clk);
  endtask

  // Digest receiver: random stall bursts, one long hold on request
  initial begin
    dout.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        dout.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        dout.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        dout.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    int msgs;
    din.valid <= 1'b0;
    din.operation <= OP_ABSORB;
    din.data_byte <= 8'h00;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty message, twice in a row to see the state come back
    send_item(OP_FINISH, 8'hFF);
    send_item(OP_FINISH, 8'h00);
    // "abc"
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_item(OP_FINISH, 8'h55);
    // Byte extremes
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hFF);
    send_item(OP_ABSORB, 8'hFF);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hAA);
    send_item(OP_FINISH, 8'hAA);

    // Sender pauses until all digests are out
    wait_digests();

    msgs = 0;
    while (items < 250) begin
      // Final stretch runs without idling
      if (items >= 220) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      // Receiver holds off while a short message and more bytes keep coming
      if (msgs == 2) begin
        hold_req = 1'b1;
        send_message(HOLD_MSG_LEN);
      end else begin
        send_message(pick_length());
      end
      msgs++;
    end

    wait_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && words_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sha1_stream_hasher.f */
sv/sha1s_pkg.sv
sv/sha1s_if.sv
sv/sha1s_datapath.sv
sv/sha1s_ctrl.sv
sv/sha1_stream_hasher.sv
sv/sha1s_checker.sv
tb/sha1_digest_checker.sv
tb/tb.sv
